FILE: hw/rtl/ffca_pkg.sv
// Shared types and constants of the first-fit cell allocator.
// Holds the request/response beat structs, operation codes and sizing defaults.
// No dependencies.
package ffca_pkg;

    localparam int CELLS_DEF      = 1024;
    localparam int OWNER_BITS_DEF = 10;

    localparam int CFG_W   = 11;
    localparam int SIZE_W  = 11;
    localparam int OWNER_W = 10;
    localparam int START_W = 10;
    localparam int FREED_W = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [SIZE_W-1:0]  block_size;
        logic [OWNER_W-1:0] owner_id;
    } ffca_req_t;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] start_index;
        logic [FREED_W-1:0] freed_count;
    } ffca_rsp_t;

endpackage

FILE: hw/rtl/ffca_tag_ram.sv
// Owner tag store of the first-fit cell allocator.
// Single write port, single read port, registered read data; depends on ffca_pkg.
module ffca_tag_ram #(
    parameter int DEPTH = ffca_pkg::CELLS_DEF,
    parameter int WIDTH = ffca_pkg::OWNER_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/first_fit_cell_allocator.sv
// Top level of the first-fit cell allocator: request sequencer and result register.
// Depends on ffca_pkg and ffca_tag_ram.
//
// The block keeps an owner tag per cell in one synchronous RAM (tag 0 = free). An
// allocate beat walks the managed cells from cell 0, one RAM read per cycle, counting
// the current run of free cells; on the first run of block_size cells it stops and
// writes the owner into that run, one cell per cycle, and returns the run's first
// cell. A free beat walks every managed cell and writes 0 into each cell that holds
// the owner, in the cycle after its read, and returns the count. The managed cell
// count n is min(cells_in_use, CELLS), sampled when the beat is taken. Requests that
// cannot succeed (owner 0, or for an allocate block_size 0 or larger than n) skip
// the walk and go straight to the result. The result waits in the sequencer while
// the output register still holds an untaken beat. One request is in work at a
// time; s_ready drops while a request is in work and rises as the result is loaded
// into the output register, and the next beat can be taken while the previous
// result still waits in the output register.
// After reset the block sweeps every cell of the RAM to zero with s_ready low;
// configuration writes are taken during that sweep. Write cells_in_use only while
// the block is idle.
module first_fit_cell_allocator #(
    parameter int CELLS      = ffca_pkg::CELLS_DEF,
    parameter int OWNER_BITS = ffca_pkg::OWNER_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [ffca_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ffca_pkg::ffca_req_t             s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ffca_pkg::ffca_rsp_t             m_data
);

    import ffca_pkg::*;

    // Cell index width, count width (must hold CELLS itself) and compare width.
    localparam int IDX_W = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_FILL  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      cfg_reg, cfg_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;

    // Request context, captured when the beat is taken.
    logic                  op_reg, op_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [CNT_W-1:0]      want_reg, want_next;
    logic [CNT_W-1:0]      n_reg, n_next;

    // Scan pipeline: rd_cnt is the next cell to read, rd_idx the cell whose tag
    // is on the RAM output when rd_valid is set.
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]      run_reg, run_next;

    // Fill walk over the found run.
    logic [IDX_W-1:0]      fill_ptr_reg, fill_ptr_next;
    logic [IDX_W-1:0]      fill_end_reg, fill_end_next;

    // Result of the request in work.
    logic                  res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]      start_reg, start_next;
    logic [CNT_W-1:0]      freed_reg, freed_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    ffca_rsp_t             m_data_reg, m_data_next;

    // RAM ports.
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [OWNER_BITS-1:0] wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [OWNER_BITS-1:0] rd_data;
    logic                  rd_issue;

    // Helpers.
    logic [OWNER_BITS+OWNER_W-1:0] owner_ext;
    logic [OWNER_BITS-1:0]         s_owner;
    logic [CMP_W-1:0]              cfg_cmp;
    logic [CMP_W-1:0]              cells_cmp;
    logic [CNT_W-1:0]              s_n;
    logic [CMP_W-1:0]              s_want_cmp;
    logic                          s_fast_fail;
    logic [CNT_W-1:0]              run_inc;
    logic [CNT_W-1:0]              start_full;
    logic [IDX_W+START_W-1:0]      start_ext;
    logic [CNT_W+FREED_W-1:0]      freed_ext;
    logic                          s_take;

    ffca_tag_ram #(
        .DEPTH(CELLS),
        .WIDTH(OWNER_BITS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign s_take  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Decode the incoming beat: masked owner, managed count, cheap failure check.
    assign owner_ext   = (OWNER_BITS + OWNER_W)'(s_data.owner_id);
    assign s_owner     = owner_ext[OWNER_BITS-1:0];
    assign cfg_cmp     = CMP_W'(cfg_reg);
    assign cells_cmp   = CMP_W'(CELLS);
    assign s_n         = (cfg_cmp > cells_cmp) ? CNT_W'(cells_cmp) : CNT_W'(cfg_cmp);
    assign s_want_cmp  = CMP_W'(s_data.block_size);
    assign s_fast_fail = (s_owner == '0) || (s_want_cmp == '0) ||
                         (s_want_cmp > CMP_W'(s_n));

    assign run_inc    = run_reg + CNT_W'(1);
    assign start_full = CNT_W'(rd_idx_reg) + CNT_W'(1) - want_reg;
    assign start_ext  = (IDX_W + START_W)'(start_reg);
    assign freed_ext  = (CNT_W + FREED_W)'(freed_reg);

    assign rd_issue = (state_reg == ST_SCAN) && (rd_cnt_reg < n_reg);
    assign rd_addr  = rd_cnt_reg[IDX_W-1:0];

    always_comb begin
        state_next    = state_reg;
        cfg_next      = cfg_reg;
        clr_cnt_next  = clr_cnt_reg;
        op_next       = op_reg;
        owner_next    = owner_reg;
        want_next     = want_reg;
        n_next        = n_reg;
        rd_cnt_next   = rd_cnt_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        run_next      = run_reg;
        fill_ptr_next = fill_ptr_reg;
        fill_end_next = fill_end_reg;
        res_ok_next   = res_ok_reg;
        start_next    = start_reg;
        freed_next    = freed_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_addr       = clr_cnt_reg;
        wr_data       = '0;

        if (cfg_wr_en) begin
            cfg_next = cfg_wr_data;
        end

        // Drop the result once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_take) begin
                    op_next     = s_data.operation;
                    owner_next  = s_owner;
                    want_next   = CNT_W'(s_want_cmp);
                    n_next      = s_n;
                    rd_cnt_next = '0;
                    run_next    = '0;
                    start_next  = '0;
                    freed_next  = '0;
                    if (s_data.operation == OP_FREE) begin
                        res_ok_next = 1'b1;
                        state_next  = (s_owner == '0) ? ST_DONE : ST_SCAN;
                    end else begin
                        res_ok_next = 1'b0;
                        state_next  = s_fast_fail ? ST_DONE : ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (rd_issue) begin
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                    rd_idx_next   = rd_cnt_reg[IDX_W-1:0];
                end
                if (rd_valid_reg) begin
                    if (op_reg == OP_ALLOC) begin
                        if (rd_data == '0) begin
                            run_next = run_inc;
                            if (run_inc == want_reg) begin
                                // Run found: stop reading, tag it from its first cell.
                                start_next    = start_full[IDX_W-1:0];
                                fill_ptr_next = start_full[IDX_W-1:0];
                                fill_end_next = rd_idx_reg;
                                rd_valid_next = 1'b0;
                                state_next    = ST_FILL;
                            end
                        end else begin
                            run_next = '0;
                        end
                    end else begin
                        if (rd_data == owner_reg) begin
                            wr_en      = 1'b1;
                            wr_addr    = rd_idx_reg;
                            wr_data    = '0;
                            freed_next = freed_reg + CNT_W'(1);
                        end
                    end
                end else if (!rd_issue) begin
                    // Nothing in flight and nothing left to read.
                    state_next = ST_DONE;
                end
            end

            ST_FILL: begin
                wr_en         = 1'b1;
                wr_addr       = fill_ptr_reg;
                wr_data       = owner_reg;
                fill_ptr_next = fill_ptr_reg + IDX_W'(1);
                if (fill_ptr_reg == fill_end_reg) begin
                    res_ok_next = 1'b1;
                    state_next  = ST_DONE;
                end
            end

            ST_DONE: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.success     = res_ok_reg;
                    m_data_next.start_index = res_ok_reg ? start_ext[START_W-1:0] : '0;
                    m_data_next.freed_count = freed_ext[FREED_W-1:0];
                    state_next              = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cfg_reg      <= CFG_RESET;
            clr_cnt_reg  <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            clr_cnt_reg  <= clr_cnt_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        owner_reg    <= owner_next;
        want_reg     <= want_next;
        n_reg        <= n_next;
        rd_cnt_reg   <= rd_cnt_next;
        rd_idx_reg   <= rd_idx_next;
        run_reg      <= run_next;
        fill_ptr_reg <= fill_ptr_next;
        fill_end_reg <= fill_end_next;
        res_ok_reg   <= res_ok_next;
        start_reg    <= start_next;
        freed_reg    <= freed_next;
        m_data_reg   <= m_data_next;
    end

`ifndef SYNTHESIS
    // A write-back during the scan never hits the cell being read in that cycle.
    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_issue) |-> (wr_addr != rd_addr))
        else $error("tag RAM write and read collide on one cell");

    // The free-cell run never reaches the block size without stopping the scan.
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && op_reg == OP_ALLOC) |-> (run_reg < want_reg))
        else $error("free run overran the requested size");

    // The fill walk stays inside the found run.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> (fill_ptr_reg <= fill_end_reg))
        else $error("fill pointer past end of run");

    // A failed request never reports a start cell.
    a_fail_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.success) |-> (m_data.start_index == '0))
        else $error("failed allocate reports nonzero start");

    // No beat is taken before the reset sweep of the tag RAM ends.
    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg == ST_CLEAR) |-> !$past(s_take))
        else $error("request taken during reset sweep");
`endif

endmodule
